### rtl/hsv_pkg.sv
// Shared constants, types and the sector code set for the HSV to RGB pipeline.
`default_nettype none

package hsv_pkg;

    localparam int HUE_W   = 16;
    localparam int PCT_W   = 7;
    localparam int CHAN_W  = 8;
    localparam int HMOD_W  = 9;   // hue after mod 360
    localparam int REM_W   = 6;   // remainder within a 60 degree sector
    localparam int QUOT_W  = 8;   // hue / 360 for a 16 bit hue

    localparam int PIPE_DEPTH = 6;

    localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
    localparam logic [HMOD_W-1:0] FULL_CIRCLE = 9'd360;
    localparam logic [REM_W-1:0]  SECTOR_SPAN = 6'd60;

    // floor(x/360) for x < 2^16: (x * 46604) >> 24
    localparam logic [15:0] DIV360_MUL   = 16'd46604;
    localparam int          DIV360_SHIFT = 24;

    // floor(v*255/100) for v <= 100: (v * 255 * 5243) >> 19
    localparam logic [20:0] TOP_MUL      = 21'd1336965;
    // floor(x/100) for x <= 25500: (x * 5243) >> 19
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // floor(x/60) for x < 360: (x * 1093) >> 16
    localparam logic [10:0] DIV60S_MUL   = 11'd1093;
    localparam int          DIV60S_SHIFT = 16;
    // floor(x/60) for x < 16384: (x * 17477) >> 20
    localparam logic [14:0] DIV60_MUL    = 15'd17477;
    localparam int          DIV60_SHIFT  = 20;

    // sector codes: which channel is held high and which one ramps
    typedef enum logic [2:0] {
        SEC_R_GUP = 3'd0,
        SEC_G_RDN = 3'd1,
        SEC_G_BUP = 3'd2,
        SEC_B_GDN = 3'd3,
        SEC_B_RUP = 3'd4,
        SEC_R_BDN = 3'd5
    } sector_t;

    typedef struct packed {
        logic adv;        // whole pipeline moves one stage
        logic out_valid;  // last stage holds a result
    } pipe_ctl_t;

endpackage

`default_nettype wire

### rtl/hsv_if.sv
// Valid/ready channel interfaces for HSV input and RGB output.
`default_nettype none

interface hsv_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue_degrees;
    logic [6:0]  saturation_pct;
    logic [6:0]  brightness_pct;

    modport source (output valid, output hue_degrees, output saturation_pct,
                    output brightness_pct, input ready);
    modport sink   (input valid, input hue_degrees, input saturation_pct,
                    input brightness_pct, output ready);
endinterface

interface rgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### rtl/hsv_ctrl.sv
// Pipeline valid bits and the global advance/stall control.
`default_nettype none

module hsv_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_ready,
    output hsv_pkg::pipe_ctl_t      ctl
);
    import hsv_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  adv;

    // an empty output slot or a taken result lets everything shift
    assign adv        = !valid_reg[PIPE_DEPTH-1] || out_ready;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.adv       = adv;
    assign ctl.out_valid = valid_reg[PIPE_DEPTH-1];

endmodule

`default_nettype wire

### rtl/hsv_hue_path.sv
// Hue path, stages 1-3: mod 360, then split into sector and remainder.
`default_nettype none

module hsv_hue_path (
    input  wire logic                         clk,
    input  wire logic                         adv,
    input  wire logic [hsv_pkg::HUE_W-1:0]    hue_degrees,
    output hsv_pkg::sector_t                  sector,
    output logic      [hsv_pkg::REM_W-1:0]    rem
);
    import hsv_pkg::*;

    logic [2*HUE_W-1:0]  qprod;
    logic [QUOT_W-1:0]   quot_reg;
    logic [HUE_W-1:0]    hue_reg;
    logic [HUE_W:0]      hmod_wide;
    logic [HMOD_W-1:0]   hmod_reg;
    logic [HMOD_W+10:0]  sprod;
    logic [2:0]          sec_raw;
    logic [HMOD_W-1:0]   sec_base;
    logic [HMOD_W-1:0]   rem_wide;
    sector_t             sector_reg;
    logic [REM_W-1:0]    rem_reg;

    // stage 1: quotient by reciprocal
    assign qprod = (2*HUE_W)'(hue_degrees) * (2*HUE_W)'(DIV360_MUL);

    // stage 2: remainder = hue - q*360
    assign hmod_wide = {1'b0, hue_reg} - ((HUE_W+1)'(quot_reg) * (HUE_W+1)'(FULL_CIRCLE));

    // stage 3: sector = hmod/60, rem = hmod - sector*60
    assign sprod    = (HMOD_W+11)'(hmod_reg) * (HMOD_W+11)'(DIV60S_MUL);
    assign sec_raw  = sprod[DIV60S_SHIFT+2:DIV60S_SHIFT];
    assign sec_base = HMOD_W'(sec_raw) * HMOD_W'(SECTOR_SPAN);
    assign rem_wide = hmod_reg - sec_base;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quot_reg   <= qprod[DIV360_SHIFT+QUOT_W-1:DIV360_SHIFT];
            hue_reg    <= hue_degrees;
            hmod_reg   <= hmod_wide[HMOD_W-1:0];
            sector_reg <= sector_t'(sec_raw);
            rem_reg    <= rem_wide[REM_W-1:0];
        end
    end

    assign sector = sector_reg;
    assign rem    = rem_reg;

endmodule

`default_nettype wire

### rtl/hsv_level_path.sv
// Level path, stages 1-3: clamp percentages, top and bottom intensity levels.
`default_nettype none

module hsv_level_path (
    input  wire logic                         clk,
    input  wire logic                         adv,
    input  wire logic [hsv_pkg::PCT_W-1:0]    saturation_pct,
    input  wire logic [hsv_pkg::PCT_W-1:0]    brightness_pct,
    output logic      [hsv_pkg::CHAN_W-1:0]   top,
    output logic      [hsv_pkg::CHAN_W-1:0]   bottom
);
    import hsv_pkg::*;

    logic [PCT_W-1:0]          sat_c;
    logic [PCT_W-1:0]          val_c;
    logic [PCT_W+20:0]         tprod;
    logic [CHAN_W-1:0]         top1_reg;
    logic [PCT_W-1:0]          sat1_reg;
    logic [CHAN_W+PCT_W-1:0]   bprod_reg;
    logic [CHAN_W-1:0]         top2_reg;
    logic [CHAN_W+PCT_W+12:0]  bdiv;
    logic [CHAN_W-1:0]         top3_reg;
    logic [CHAN_W-1:0]         bottom_reg;

    assign sat_c = (saturation_pct > PCT_MAX) ? PCT_MAX : saturation_pct;
    assign val_c = (brightness_pct > PCT_MAX) ? PCT_MAX : brightness_pct;

    // stage 1: top = floor(v*255/100)
    assign tprod = (PCT_W+21)'(val_c) * (PCT_W+21)'(TOP_MUL);

    // stage 3: bottom = floor(top*(100-s)/100)
    assign bdiv = (CHAN_W+PCT_W+13)'(bprod_reg) * (CHAN_W+PCT_W+13)'(DIV100_MUL);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            top1_reg   <= tprod[DIV100_SHIFT+CHAN_W-1:DIV100_SHIFT];
            sat1_reg   <= PCT_MAX - sat_c;
            bprod_reg  <= (CHAN_W+PCT_W)'(top1_reg) * (CHAN_W+PCT_W)'(sat1_reg);
            top2_reg   <= top1_reg;
            bottom_reg <= bdiv[DIV100_SHIFT+CHAN_W-1:DIV100_SHIFT];
            top3_reg   <= top2_reg;
        end
    end

    assign top    = top3_reg;
    assign bottom = bottom_reg;

endmodule

`default_nettype wire

### rtl/hsv_mix.sv
// Mix stages 4-6: ramp amount and per-sector channel selection.
`default_nettype none

module hsv_mix (
    input  wire logic                         clk,
    input  wire logic                         adv,
    input  wire hsv_pkg::sector_t             sector,
    input  wire logic [hsv_pkg::REM_W-1:0]    rem,
    input  wire logic [hsv_pkg::CHAN_W-1:0]   top,
    input  wire logic [hsv_pkg::CHAN_W-1:0]   bottom,
    output logic      [hsv_pkg::CHAN_W-1:0]   red,
    output logic      [hsv_pkg::CHAN_W-1:0]   green,
    output logic      [hsv_pkg::CHAN_W-1:0]   blue
);
    import hsv_pkg::*;

    logic [CHAN_W-1:0]        diff;
    logic [CHAN_W+REM_W-1:0]  rprod_reg;
    sector_t                  sec4_reg;
    sector_t                  sec5_reg;
    logic [CHAN_W-1:0]        top4_reg;
    logic [CHAN_W-1:0]        bot4_reg;
    logic [CHAN_W-1:0]        top5_reg;
    logic [CHAN_W-1:0]        bot5_reg;
    logic [CHAN_W+REM_W+14:0] rdiv;
    logic [CHAN_W-1:0]        ramp_reg;
    logic [CHAN_W-1:0]        rise;
    logic [CHAN_W-1:0]        fall;
    logic [CHAN_W-1:0]        red_next;
    logic [CHAN_W-1:0]        green_next;
    logic [CHAN_W-1:0]        blue_next;
    logic [CHAN_W-1:0]        red_reg;
    logic [CHAN_W-1:0]        green_reg;
    logic [CHAN_W-1:0]        blue_reg;

    assign diff = top - bottom;   // top never below bottom
    assign rdiv = (CHAN_W+REM_W+15)'(rprod_reg) * (CHAN_W+REM_W+15)'(DIV60_MUL);
    assign rise = bot5_reg + ramp_reg;
    assign fall = top5_reg - ramp_reg;

    always_comb
    begin
        red_next   = top5_reg;
        green_next = bot5_reg;
        blue_next  = fall;
        case (sec5_reg)
            SEC_R_GUP:
            begin
                red_next = top5_reg; green_next = rise; blue_next = bot5_reg;
            end
            SEC_G_RDN:
            begin
                red_next = fall; green_next = top5_reg; blue_next = bot5_reg;
            end
            SEC_G_BUP:
            begin
                red_next = bot5_reg; green_next = top5_reg; blue_next = rise;
            end
            SEC_B_GDN:
            begin
                red_next = bot5_reg; green_next = fall; blue_next = top5_reg;
            end
            SEC_B_RUP:
            begin
                red_next = rise; green_next = bot5_reg; blue_next = top5_reg;
            end
            default:
            begin
                red_next = top5_reg; green_next = bot5_reg; blue_next = fall;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 4
            rprod_reg <= (CHAN_W+REM_W)'(diff) * (CHAN_W+REM_W)'(rem);
            sec4_reg  <= sector;
            top4_reg  <= top;
            bot4_reg  <= bottom;
            // stage 5
            ramp_reg  <= rdiv[DIV60_SHIFT+CHAN_W-1:DIV60_SHIFT];
            sec5_reg  <= sec4_reg;
            top5_reg  <= top4_reg;
            bot5_reg  <= bot4_reg;
            // stage 6: output register
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter.
// Converts hue (degrees, any 16-bit value, taken mod 360), saturation and
// brightness (percent, above 100 treated as 100) to 8-bit red, green and blue.
// Six register stages, one transfer per clock when the output is not stalled.
// The last stage is the output register; a stall there freezes all stages
// together, so input ready follows output ready whenever a result is waiting.
// No state is kept between items.
`default_nettype none

module hsv_to_rgb_converter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hsv_in_if.sink     hsv_in,
    rgb_out_if.source  rgb_out
);
    import hsv_pkg::*;

    pipe_ctl_t          ctl;
    sector_t            sector;
    logic [REM_W-1:0]   rem;
    logic [CHAN_W-1:0]  top;
    logic [CHAN_W-1:0]  bottom;

    hsv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv_in.valid),
        .out_ready (rgb_out.ready),
        .ctl       (ctl)
    );

    hsv_hue_path u_hue (
        .clk         (clk),
        .adv         (ctl.adv),
        .hue_degrees (hsv_in.hue_degrees),
        .sector      (sector),
        .rem         (rem)
    );

    hsv_level_path u_level (
        .clk            (clk),
        .adv            (ctl.adv),
        .saturation_pct (hsv_in.saturation_pct),
        .brightness_pct (hsv_in.brightness_pct),
        .top            (top),
        .bottom         (bottom)
    );

    hsv_mix u_mix (
        .clk    (clk),
        .adv    (ctl.adv),
        .sector (sector),
        .rem    (rem),
        .top    (top),
        .bottom (bottom),
        .red    (rgb_out.red),
        .green  (rgb_out.green),
        .blue   (rgb_out.blue)
    );

    assign hsv_in.ready  = ctl.adv;
    assign rgb_out.valid = ctl.out_valid;

endmodule

`default_nettype wire

### rtl/hsv_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
`default_nettype none

module hsv_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [6:0] saturation_pct,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue))
        else $error("stalled result changed");

    // a waiting result blocks new input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // with no stall and no reset across the pipeline, out_valid marks exactly the taken inputs
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
        && $past(rst_n, 5) && $past(rst_n, 6)
        && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
        && $past(out_ready, 4) && $past(out_ready, 5) && $past(out_ready, 6)
        |-> out_valid == ($past(in_valid, 6) && $past(in_ready, 6)))
        else $error("result latency mismatch");

    // zero saturation gives a gray result
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
        && $past(rst_n, 5) && $past(rst_n, 6)
        && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
        && $past(out_ready, 4) && $past(out_ready, 5) && $past(out_ready, 6)
        && $past(in_valid, 6) && $past(saturation_pct, 6) == 7'd0
        |-> red == green && green == blue)
        else $error("unsaturated input not gray");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (hsv_in.valid),
    .in_ready       (hsv_in.ready),
    .saturation_pct (hsv_in.saturation_pct),
    .out_valid      (rgb_out.valid),
    .out_ready      (rgb_out.ready),
    .red            (rgb_out.red),
    .green          (rgb_out.green),
    .blue           (rgb_out.blue)
);

`default_nettype wire

### tb/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for the HSV to RGB converter: stalls, clamping, hue wrap, all sectors.
`default_nettype none

module tb_hsv_to_rgb_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import hsv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STALL_CYCLES   = 48;
    localparam int IDLE_PCT       = 32;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] bri;
    } hsv_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    logic clk;
    logic rst_n;

    hsv_in_if  in_ch ();
    rgb_out_if out_ch ();

    hsv_to_rgb_converter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .hsv_in  (in_ch.sink),
        .rgb_out (out_ch.source)
    );

    hsv_item_t hsv_pending_q[$];
    rgb_t      rgb_expected_q[$];

    int unsigned total_items;
    int unsigned in_count;
    int unsigned out_count;
    int unsigned mismatch_count;
    int unsigned clamped_count;
    int unsigned wrapped_count;
    int unsigned hold_left;
    logic        hold_done;
    int unsigned quiet_cycles;

    function automatic rgb_t predict_rgb(hsv_item_t it);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned top;
        int unsigned bottom;
        int unsigned ramp;
        int unsigned pct_max;
        int unsigned span;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        sector_t     sec;
        rgb_t        c;
        pct_max = int'(PCT_MAX);
        span    = int'(SECTOR_SPAN);
        h       = int'(it.hue) % int'(FULL_CIRCLE);
        s       = (int'(it.sat) > pct_max) ? pct_max : int'(it.sat);
        v       = (int'(it.bri) > pct_max) ? pct_max : int'(it.bri);
        top     = (v * ((1 << CHAN_W) - 1)) / pct_max;
        bottom  = (top * (pct_max - s)) / pct_max;
        ramp    = ((top - bottom) * (h % span)) / span;
        sec     = sector_t'(h / span);
        case (sec)
            SEC_R_GUP:
            begin
                r = top; g = bottom + ramp; b = bottom;
            end
            SEC_G_RDN:
            begin
                r = top - ramp; g = top; b = bottom;
            end
            SEC_G_BUP:
            begin
                r = bottom; g = top; b = bottom + ramp;
            end
            SEC_B_GDN:
            begin
                r = bottom; g = top - ramp; b = top;
            end
            SEC_B_RUP:
            begin
                r = bottom + ramp; g = bottom; b = top;
            end
            default:
            begin
                r = top; g = bottom; b = top - ramp;
            end
        endcase
        c = '{red: CHAN_W'(r), green: CHAN_W'(g), blue: CHAN_W'(b)};
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_hsv(int unsigned h, int unsigned s, int unsigned b);
        hsv_item_t it;
        it.hue = h[HUE_W-1:0];
        it.sat = s[PCT_W-1:0];
        it.bri = b[PCT_W-1:0];
        if (h >= int'(FULL_CIRCLE))
            wrapped_count++;
        if (s > int'(PCT_MAX) || b > int'(PCT_MAX))
            clamped_count++;
        hsv_pending_q.push_back(it);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sender: new item offered once the previous one transferred or nothing was offered.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        hsv_item_t nxt;
        logic      idle;
        if (!rst_n)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.hue_degrees    <= '0;
            in_ch.saturation_pct <= '0;
            in_ch.brightness_pct <= '0;
            in_count             <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                rgb_expected_q.push_back(predict_rgb('{hue: in_ch.hue_degrees,
                                                       sat: in_ch.saturation_pct,
                                                       bri: in_ch.brightness_pct}));
                in_count <= in_count + 1;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                // no gaps while the output is held off, nor in the steady window
                idle = ($urandom_range(0, 99) < IDLE_PCT) && (hold_left == 0)
                       && !(in_count >= 150 && in_count < 260);
                if (hsv_pending_q.size() != 0 && !idle)
                begin
                    nxt                   = hsv_pending_q.pop_front();
                    in_ch.hue_degrees    <= nxt.hue;
                    in_ch.saturation_pct <= nxt.sat;
                    in_ch.brightness_pct <= nxt.bri;
                    in_ch.valid          <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, once, to back the pipeline up into the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && in_count >= 80)
        begin
            hold_left <= STALL_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks every result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        rgb_t want;
        logic idle;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_count    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                out_count <= out_count + 1;
                if (rgb_expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                              out_ch.red, out_ch.green, out_ch.blue));
                end
                else
                begin
                    want = rgb_expected_q.pop_front();
                    if (out_ch.red !== want.red)
                        report_mismatch($sformatf("result %0d red %0d, want %0d",
                                                  out_count, out_ch.red, want.red));
                    if (out_ch.green !== want.green)
                        report_mismatch($sformatf("result %0d green %0d, want %0d",
                                                  out_count, out_ch.green, want.green));
                    if (out_ch.blue !== want.blue)
                        report_mismatch($sformatf("result %0d blue %0d, want %0d",
                                                  out_count, out_ch.blue, want.blue));
                end
            end
            idle = ($urandom_range(0, 99) < IDLE_PCT)
                   && !(out_count >= 150 && out_count < 260);
            out_ch.ready <= (hold_left == 0) && !idle;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned h;
        int unsigned s;
        int unsigned b;
        rst_n          = 1'b0;
        mismatch_count = 0;
        clamped_count  = 0;
        wrapped_count  = 0;

        // directed: every sector edge, hue wrap, clamped and zero percents
        queue_hsv(0, 100, 100);
        queue_hsv(59, 100, 100);
        queue_hsv(60, 100, 100);
        queue_hsv(119, 100, 100);
        queue_hsv(120, 100, 100);
        queue_hsv(179, 100, 100);
        queue_hsv(180, 100, 100);
        queue_hsv(239, 100, 100);
        queue_hsv(240, 100, 100);
        queue_hsv(299, 100, 100);
        queue_hsv(300, 100, 100);
        queue_hsv(359, 100, 100);
        queue_hsv(360, 100, 100);
        queue_hsv(65535, 100, 100);
        queue_hsv(30, 0, 100);
        queue_hsv(90, 127, 127);
        queue_hsv(210, 101, 101);
        queue_hsv(45, 50, 0);
        queue_hsv(59, 100, 1);
        queue_hsv(330, 75, 50);
        queue_hsv(0, 0, 0);
        queue_hsv(65535, 127, 127);
        queue_hsv(720, 64, 33);
        queue_hsv(150, 100, 127);

        repeat (400)
        begin
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 359);
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
            b = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
            queue_hsv(h, s, b);
        end
        total_items = hsv_pending_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (in_count != total_items || rgb_expected_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        if (rgb_expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", rgb_expected_q.size()));

        $display("Converted %0d colors: %0d with hue past 360, %0d with clamped percent.",
                 out_count, wrapped_count, clamped_count);
        $display("Random source/sink gaps plus one %0d-cycle output stall; %0d errors.",
                 STALL_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
